// ===== hdl/sliding_window_min_max_mean_top_macros.svh =====
// ----------------------------------------------------------------------------
// sliding window min/max/mean assertion macros
// Shorthand for the clocked checks of the port checker.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MIN_MAX_MEAN_TOP_MACROS_SVH
`define SLIDING_WINDOW_MIN_MAX_MEAN_TOP_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define SWMM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swmm check failed");

// condition must hold in the cycle after the trigger
`define SWMM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swmm check failed");

`endif

// ===== hdl/swmm_pkg.sv =====
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared constants, types and helpers of the sliding window min/max/mean.
// ----------------------------------------------------------------------------
package swmm_pkg;

    localparam int DATA_W    = 32;
    localparam int MODE_W    = 2;
    localparam int CFG_W     = 7;
    localparam int DEPTH_DEF = 64;
    localparam logic [CFG_W-1:0] LEN_RESET = 7'd64;

    localparam logic [MODE_W-1:0] MODE_ABS  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FILL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HOLD = 2'd3;

    typedef logic signed [DATA_W-1:0] sample_t;

    // values that travel with the window sum into the divider
    typedef struct packed {
        sample_t stored;
        sample_t win_lo;
        sample_t win_hi;
    } swmm_ext_t;

    function automatic sample_t sat_add(input sample_t a, input sample_t b);
        logic signed [DATA_W:0] s;
        sample_t r;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
        begin
            r = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            r = s[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/swmm_if.sv =====
// ----------------------------------------------------------------------------
// swmm stream interfaces
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------
interface swmm_in_if;
    logic                                valid;
    logic                                ready;
    logic [swmm_pkg::MODE_W-1:0]         mode;
    logic signed [swmm_pkg::DATA_W-1:0]  sample_value;

    modport source (output valid, output mode, output sample_value, input ready);
    modport sink   (input valid, input mode, input sample_value, output ready);
endinterface

interface swmm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [swmm_pkg::DATA_W-1:0]  stored_value;
    logic signed [swmm_pkg::DATA_W-1:0]  window_min;
    logic signed [swmm_pkg::DATA_W-1:0]  window_max;
    logic signed [swmm_pkg::DATA_W-1:0]  window_mean;

    modport source (output valid, output stored_value, output window_min,
                    output window_max, output window_mean, input ready);
    modport sink   (input valid, input stored_value, input window_min,
                    input window_max, input window_mean, output ready);
endinterface

// ===== hdl/swmm_cell.sv =====
// ----------------------------------------------------------------------------
// swmm_cell
// One sample slot of the rotating ring; takes its neighbor's value on shift.
// ----------------------------------------------------------------------------
module swmm_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift_en,
    input  swmm_pkg::sample_t shift_in,
    output swmm_pkg::sample_t data_out
);

    swmm_pkg::sample_t data_reg;
    swmm_pkg::sample_t data_next;

    always_comb
    begin
        data_next = shift_en ? shift_in : data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data_out = data_reg;

endmodule

// ===== hdl/swmm_div.sv =====
// ----------------------------------------------------------------------------
// swmm_div
// Bit-serial signed divide of the window sum by the window length, plus the
// result register that drives the output channel.
// ----------------------------------------------------------------------------
module swmm_div #(
    parameter int SUM_W = 38,
    parameter int LEN_W = 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load_valid,
    output logic                    load_ready,
    input  swmm_pkg::swmm_ext_t     load_ext,
    input  logic signed [SUM_W-1:0] load_sum,
    input  logic [LEN_W-1:0]        load_len,
    swmm_out_if.source              results
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SUM_W-1:0]    q_reg, q_next;
    logic [LEN_W-1:0]    rem_reg, rem_next;
    logic [LEN_W-1:0]    d_reg, d_next;
    logic                neg_reg, neg_next;
    swmm_pkg::swmm_ext_t hold_reg, hold_next;
    logic                out_valid_reg, out_valid_next;
    swmm_pkg::swmm_ext_t out_ext_reg, out_ext_next;
    swmm_pkg::sample_t   out_mean_reg, out_mean_next;

    logic [LEN_W:0]      trial;
    logic                ge;
    logic [SUM_W-1:0]    q_signed;
    logic                slot_free;

    assign load_ready = !busy_reg && !done_reg;
    assign slot_free  = !out_valid_reg || results.ready;
    assign trial      = {rem_reg, q_reg[SUM_W-1]};
    assign ge         = trial >= {1'b0, d_reg};
    // truncation toward zero: divide magnitudes, then restore the sign
    assign q_signed   = neg_reg ? (~q_reg + SUM_W'(1)) : q_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        done_next      = done_reg;
        cnt_next       = cnt_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        d_next         = d_reg;
        neg_next       = neg_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg;
        out_ext_next   = out_ext_reg;
        out_mean_next  = out_mean_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (load_valid && load_ready)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = load_sum[SUM_W-1] ? (~load_sum + SUM_W'(1)) : load_sum;
            rem_next  = '0;
            d_next    = load_len;
            neg_next  = load_sum[SUM_W-1];
            hold_next = load_ext;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[SUM_W-2:0], ge};
            rem_next = ge ? LEN_W'(trial - {1'b0, d_reg}) : trial[LEN_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (done_reg && slot_free)
        begin
            done_next      = 1'b0;
            out_valid_next = 1'b1;
            out_ext_next   = hold_reg;
            out_mean_next  = q_signed[swmm_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            done_reg      <= done_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        rem_reg      <= rem_next;
        d_reg        <= d_next;
        neg_reg      <= neg_next;
        hold_reg     <= hold_next;
        out_ext_reg  <= out_ext_next;
        out_mean_reg <= out_mean_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.stored_value = out_ext_reg.stored;
    assign results.window_min   = out_ext_reg.win_lo;
    assign results.window_max   = out_ext_reg.win_hi;
    assign results.window_mean  = out_mean_reg;

endmodule

// ===== hdl/sliding_window_min_max_mean_top.sv =====
// A new item is taken only once the previous one has been handed to the divider.
// The first incremental item after a length write takes one extra turn unless a write or fill came first.
// The mean divider runs bit-serially alongside the next item's ring turn.
// Reset: ring cleared to zero, window length 64, positions zero, no result pending.
// ----------------------------------------------------------------------------
// sliding_window_min_max_mean_top
// Ring of sample cells rotated once per item: the value is written as its slot
// passes the head, while min, max and sum are gathered over the window.
// ----------------------------------------------------------------------------
module sliding_window_min_max_mean_top #(
    parameter int DEPTH = swmm_pkg::DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    swmm_in_if.sink                     samples,
    swmm_out_if.source                  results,
    input  logic                        cfg_wr_en,
    input  logic [swmm_pkg::CFG_W-1:0]  cfg_wr_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int SUM_W = swmm_pkg::DATA_W + IDX_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_HAND  = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [IDX_W-1:0]              k_reg, k_next;
    logic [IDX_W-1:0]              wp_reg, wp_next;
    logic [swmm_pkg::CFG_W-1:0]    len_reg, len_next;
    swmm_pkg::sample_t             prev_reg, prev_next;
    logic                          prev_ok_reg, prev_ok_next;
    logic [swmm_pkg::MODE_W-1:0]   mode_reg, mode_next;
    swmm_pkg::sample_t             sv_reg, sv_next;
    swmm_pkg::sample_t             lo_reg, lo_next;
    swmm_pkg::sample_t             hi_reg, hi_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;

    logic [LEN_W-1:0]              eff_len;
    swmm_pkg::sample_t             cell_data [DEPTH];
    swmm_pkg::sample_t             head;
    swmm_pkg::sample_t             head_new;
    swmm_pkg::sample_t             stored;
    logic                          shift_en;
    logic                          is_write;
    logic                          in_win;
    logic                          last_k;
    logic                          div_ready;
    swmm_pkg::swmm_ext_t           div_ext;

    // length 0 acts as 1, beyond the ring acts as the ring size
    always_comb
    begin
        if (len_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (32'(len_reg) > DEPTH)
        begin
            eff_len = LEN_W'(DEPTH);
        end
        else
        begin
            eff_len = LEN_W'(len_reg);
        end
    end

    assign head     = cell_data[0];
    assign shift_en = (state_reg == ST_FETCH) || (state_reg == ST_SCAN);
    assign is_write = (mode_reg == swmm_pkg::MODE_ABS) || (mode_reg == swmm_pkg::MODE_INC);
    assign in_win   = LEN_W'(k_reg) < eff_len;
    assign last_k   = k_reg == IDX_W'(DEPTH - 1);

    always_comb
    begin
        case (mode_reg)
            swmm_pkg::MODE_ABS:  stored = sv_reg;
            swmm_pkg::MODE_INC:  stored = swmm_pkg::sat_add(prev_reg, sv_reg);
            swmm_pkg::MODE_FILL: stored = sv_reg;
            default:             stored = '0;
        endcase
    end

    // value that re-enters the ring tail as the head slot moves on
    always_comb
    begin
        head_new = head;
        if (state_reg == ST_SCAN)
        begin
            if (mode_reg == swmm_pkg::MODE_FILL)
            begin
                head_new = sv_reg;
            end
            else if (is_write && (k_reg == wp_reg))
            begin
                head_new = stored;
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            swmm_pkg::sample_t nb_in;
            if (gi == DEPTH - 1)
            begin : g_tail
                assign nb_in = head_new;
            end
            else
            begin : g_mid
                assign nb_in = cell_data[gi + 1];
            end
            swmm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .shift_in (nb_in),
                .data_out (cell_data[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        wp_next      = wp_reg;
        len_next     = len_reg;
        prev_next    = prev_reg;
        prev_ok_next = prev_ok_reg;
        mode_next    = mode_reg;
        sv_next      = sv_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        sum_next     = sum_reg;

        if (shift_en)
        begin
            k_next = last_k ? '0 : k_reg + IDX_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_wr_en)
                begin
                    len_next     = cfg_wr_data;
                    wp_next      = '0;
                    prev_ok_next = 1'b0;
                end
                if (samples.valid)
                begin
                    mode_next = samples.mode;
                    sv_next   = samples.sample_value;
                    k_next    = '0;
                    if ((samples.mode == swmm_pkg::MODE_INC) && (!prev_ok_reg || cfg_wr_en))
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_FETCH:
            begin
                // pick up the last window entry, the base of an increment at slot 0
                if (LEN_W'(k_reg) == eff_len - LEN_W'(1))
                begin
                    prev_next = head;
                end
                if (last_k)
                begin
                    prev_ok_next = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (k_reg == '0)
                begin
                    lo_next  = head_new;
                    hi_next  = head_new;
                    sum_next = SUM_W'(head_new);
                end
                else if (in_win)
                begin
                    if (head_new < lo_reg)
                    begin
                        lo_next = head_new;
                    end
                    if (head_new > hi_reg)
                    begin
                        hi_next = head_new;
                    end
                    sum_next = sum_reg + SUM_W'(head_new);
                end
                if (last_k)
                begin
                    state_next = ST_HAND;
                    if (mode_reg == swmm_pkg::MODE_FILL)
                    begin
                        wp_next = '0;
                    end
                    else if (is_write)
                    begin
                        if ((LEN_W'(wp_reg) + LEN_W'(1)) >= eff_len)
                        begin
                            wp_next = '0;
                        end
                        else
                        begin
                            wp_next = wp_reg + IDX_W'(1);
                        end
                    end
                end
            end
            ST_HAND:
            begin
                if (div_ready)
                begin
                    state_next = ST_IDLE;
                    // the stored value stays on the hand-off until the divider takes it
                    if (is_write || (mode_reg == swmm_pkg::MODE_FILL))
                    begin
                        prev_next    = stored;
                        prev_ok_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            wp_reg      <= '0;
            len_reg     <= swmm_pkg::LEN_RESET;
            prev_reg    <= '0;
            prev_ok_reg <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            wp_reg      <= wp_next;
            len_reg     <= len_next;
            prev_reg    <= prev_next;
            prev_ok_reg <= prev_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        sv_reg   <= sv_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        sum_reg  <= sum_next;
    end

    assign samples.ready  = state_reg == ST_IDLE;
    assign div_ext.stored = stored;
    assign div_ext.win_lo = lo_reg;
    assign div_ext.win_hi = hi_reg;

    swmm_div #(
        .SUM_W (SUM_W),
        .LEN_W (LEN_W)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (state_reg == ST_HAND),
        .load_ready (div_ready),
        .load_ext   (div_ext),
        .load_sum   (sum_reg),
        .load_len   (eff_len),
        .results    (results)
    );

endmodule

// ===== hdl/swmm_chk.sv =====
// ----------------------------------------------------------------------------
// swmm_chk
// Port-level checks of the sliding window block, bound to the top level.
// ----------------------------------------------------------------------------
`include "sliding_window_min_max_mean_top_macros.svh"

module swmm_chk (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [swmm_pkg::DATA_W-1:0] out_min,
    input logic signed [swmm_pkg::DATA_W-1:0] out_max,
    input logic signed [swmm_pkg::DATA_W-1:0] out_mean
);

    // a pending result beat is not dropped
    `SWMM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // one item in work at a time
    `SWMM_ASSERT_NEXT(a_in_busy, in_valid && in_ready, !in_ready)

    `SWMM_ASSERT_NOW(a_min_le_max, out_valid, out_min <= out_max)

    // the truncated mean lies between the window extremes
    `SWMM_ASSERT_NOW(a_mean_range, out_valid, (out_mean >= out_min) && (out_mean <= out_max))

endmodule

bind sliding_window_min_max_mean_top swmm_chk u_swmm_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_min   (results.window_min),
    .out_max   (results.window_max),
    .out_mean  (results.window_mean)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives sample beats through the sliding window block under several window
// lengths and checks every result beat against an in-bench window predictor.
// ----------------------------------------------------------------------------
module tb_top;

    typedef swmm_pkg::sample_t                sample_t;
    typedef logic [swmm_pkg::MODE_W-1:0]      mode_t;
    typedef logic [swmm_pkg::CFG_W-1:0]       len_cfg_t;

    localparam int          RING_DEPTH  = swmm_pkg::DEPTH_DEF;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          PHASES      = 11;
    localparam int          PHASE_BEATS = 68;
    localparam int          TAIL_CYCLES = 200;
    localparam sample_t     S_MAX       = 32'sh7FFF_FFFF;
    localparam sample_t     S_MIN       = 32'sh8000_0000;

    typedef struct packed {
        mode_t             mode;
        sample_t           value;
    } sample_beat_t;

    typedef struct packed {
        sample_t stored;
        sample_t lo;
        sample_t hi;
        sample_t mean;
    } window_stats_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    len_cfg_t            cfg_wr_data;

    swmm_in_if  samples_if();
    swmm_out_if results_if();

    sliding_window_min_max_mean_top #(
        .DEPTH (RING_DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples_if),
        .results     (results_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // predictor state
    sample_t             win_ring [RING_DEPTH];
    int unsigned         wr_pos;
    int unsigned         lo_pos;
    int unsigned         hi_pos;
    longint              win_sum;
    len_cfg_t            win_len_cfg;

    sample_beat_t        beats_pending [$];
    window_stats_t       stats_due [$];
    int unsigned         beats_queued;
    int unsigned         stats_checked;
    int unsigned         error_count;
    int unsigned         cycle_count;
    bit                  allow_idle;
    int unsigned         send_gap;
    int unsigned         take_gap;
    sample_beat_t        next_beat;
    window_stats_t       want;

    function automatic int unsigned used_len();
        if (win_len_cfg == '0)
        begin
            return 1;
        end
        if (win_len_cfg > RING_DEPTH)
        begin
            return RING_DEPTH;
        end
        return win_len_cfg;
    endfunction

    // scans keep the start entry unless a strictly better one shows up
    function automatic int unsigned find_lowest(input int unsigned start, input int unsigned n);
        int unsigned pick;
        pick = start;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (win_ring[i] < win_ring[pick])
            begin
                pick = i;
            end
        end
        return pick;
    endfunction

    function automatic int unsigned find_highest(input int unsigned start, input int unsigned n);
        int unsigned pick;
        pick = start;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (win_ring[i] > win_ring[pick])
            begin
                pick = i;
            end
        end
        return pick;
    endfunction

    function automatic window_stats_t advance_window(input mode_t mode,
                                                     input sample_t value);
        int unsigned   n;
        int unsigned   wp;
        int unsigned   prev;
        longint        acc;
        window_stats_t res;
        n = used_len();
        if (wr_pos >= n)
        begin
            wr_pos = 0;
        end
        if (lo_pos >= n)
        begin
            lo_pos = 0;
        end
        if (hi_pos >= n)
        begin
            hi_pos = 0;
        end
        res.stored = '0;
        case (mode)
            swmm_pkg::MODE_FILL:
            begin
                for (int i = 0; i < RING_DEPTH; i++)
                begin
                    win_ring[i] = value;
                end
                wr_pos = 0;
                lo_pos = 0;
                hi_pos = 0;
                win_sum = longint'(value) * longint'(n);
                res.stored = value;
            end
            swmm_pkg::MODE_ABS, swmm_pkg::MODE_INC:
            begin
                wp = wr_pos;
                acc = longint'(value);
                if (mode == swmm_pkg::MODE_INC)
                begin
                    // newest entry sits just behind the write slot, wrapping at the length
                    prev = ((wp != 0) ? wp : n) - 1;
                    acc = longint'(win_ring[prev]) + longint'(value);
                    if (acc > longint'(S_MAX))
                    begin
                        acc = longint'(S_MAX);
                    end
                    if (acc < longint'(S_MIN))
                    begin
                        acc = longint'(S_MIN);
                    end
                end
                res.stored = sample_t'(acc);
                win_sum += acc - longint'(win_ring[wp]);
                win_ring[wp] = res.stored;
                if (lo_pos == wp)
                begin
                    lo_pos = find_lowest(wp, n);
                end
                else if (res.stored < win_ring[lo_pos])
                begin
                    lo_pos = wp;
                end
                if (hi_pos == wp)
                begin
                    hi_pos = find_highest(wp, n);
                end
                else if (res.stored > win_ring[hi_pos])
                begin
                    hi_pos = wp;
                end
                wr_pos = (wp + 1 >= n) ? 0 : wp + 1;
            end
            default:
            begin
                // hold: window untouched, stored reads zero
            end
        endcase
        res.lo   = win_ring[lo_pos];
        res.hi   = win_ring[hi_pos];
        res.mean = sample_t'(win_sum / longint'(n));
        return res;
    endfunction

    function automatic sample_t pick_value();
        sample_t v;
        case ($urandom_range(0, 5))
            0, 1:
            begin
                v = sample_t'($urandom);
            end
            2:
            begin
                case ($urandom_range(0, 3))
                    0: v = S_MAX;
                    1: v = S_MIN;
                    2: v = S_MAX - 1;
                    default: v = S_MIN + 1;
                endcase
            end
            3, 4:
            begin
                // narrow range so ties between entries are common
                v = sample_t'(int'($urandom_range(0, 16)) - 8);
            end
            default:
            begin
                v = sample_t'($urandom) >>> 12;
            end
        endcase
        return v;
    endfunction

    task automatic queue_beat(input mode_t mode, input sample_t value);
        sample_beat_t b;
        b.mode  = mode;
        b.value = value;
        beats_pending.push_back(b);
        beats_queued++;
    endtask

    task automatic wait_drained();
        while (stats_checked != beats_queued)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_if.valid        <= 1'b0;
            samples_if.mode         <= '0;
            samples_if.sample_value <= '0;
            send_gap = 0;
        end
        else
        begin
            if (samples_if.valid && samples_if.ready)
            begin
                stats_due.push_back(advance_window(samples_if.mode, samples_if.sample_value));
            end
            if (!samples_if.valid || samples_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    samples_if.valid <= 1'b0;
                end
                else if (allow_idle && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(0, 9);
                    samples_if.valid <= 1'b0;
                end
                else if (beats_pending.size() != 0)
                begin
                    next_beat = beats_pending.pop_front();
                    samples_if.valid        <= 1'b1;
                    samples_if.mode         <= next_beat.mode;
                    samples_if.sample_value <= next_beat.value;
                end
                else
                begin
                    samples_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
            take_gap = 0;
        end
        else
        begin
            if (results_if.valid && results_if.ready)
            begin
                if (stats_due.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, got stored %0d min %0d",
                             $time, results_if.stored_value, results_if.window_min);
                    $display("%0t: unexpected beat also carries max %0d mean %0d",
                             $time, results_if.window_max, results_if.window_mean);
                    error_count++;
                end
                else
                begin
                    want = stats_due.pop_front();
                    stats_checked++;
                    if (results_if.stored_value !== want.stored)
                    begin
                        $display("%0t: stored_value expected %0d, got %0d",
                                 $time, want.stored, results_if.stored_value);
                        error_count++;
                    end
                    if (results_if.window_min !== want.lo)
                    begin
                        $display("%0t: window_min expected %0d, got %0d",
                                 $time, want.lo, results_if.window_min);
                        error_count++;
                    end
                    if (results_if.window_max !== want.hi)
                    begin
                        $display("%0t: window_max expected %0d, got %0d",
                                 $time, want.hi, results_if.window_max);
                        error_count++;
                    end
                    if (results_if.window_mean !== want.mean)
                    begin
                        $display("%0t: window_mean expected %0d, got %0d",
                                 $time, want.mean, results_if.window_mean);
                        error_count++;
                    end
                end
            end
            if (take_gap > 0)
            begin
                take_gap--;
                results_if.ready <= 1'b0;
            end
            else if (allow_idle && $urandom_range(0, 9) == 0)
            begin
                take_gap = $urandom_range(0, 9);
                results_if.ready <= 1'b0;
            end
            else
            begin
                results_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d of %0d results checked",
                     $time, stats_checked, beats_queued);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        len_cfg_t         phase_len [PHASES];
        int unsigned      n;
        int unsigned      r;
        sample_t          v;

        rst_n                   = 1'b0;
        cfg_wr_en               = 1'b0;
        cfg_wr_data             = '0;
        samples_if.valid        = 1'b0;
        samples_if.mode         = '0;
        samples_if.sample_value = '0;
        results_if.ready        = 1'b0;
        allow_idle              = 1'b1;
        beats_queued            = 0;
        stats_checked           = 0;
        error_count             = 0;
        cycle_count             = 0;

        for (int i = 0; i < RING_DEPTH; i++)
        begin
            win_ring[i] = '0;
        end
        wr_pos      = 0;
        lo_pos      = 0;
        hi_pos      = 0;
        win_sum     = 0;
        win_len_cfg = swmm_pkg::LEN_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // increment at slot zero reads the last entry of the window
        queue_beat(swmm_pkg::MODE_INC,  32'sd5);
        queue_beat(swmm_pkg::MODE_ABS,  S_MAX);
        queue_beat(swmm_pkg::MODE_INC,  32'sd1);
        queue_beat(swmm_pkg::MODE_ABS,  S_MIN);
        queue_beat(swmm_pkg::MODE_INC,  -32'sd1);
        queue_beat(swmm_pkg::MODE_ABS,  -32'sd1);
        queue_beat(swmm_pkg::MODE_ABS,  32'sd0);
        queue_beat(swmm_pkg::MODE_HOLD, 32'sh5A5A_5A5A);
        queue_beat(swmm_pkg::MODE_FILL, S_MAX);
        queue_beat(swmm_pkg::MODE_INC,  S_MAX);
        queue_beat(swmm_pkg::MODE_ABS,  S_MIN);
        queue_beat(swmm_pkg::MODE_FILL, S_MIN);
        // overwrite the slot holding both extremes, forcing a rescan
        queue_beat(swmm_pkg::MODE_ABS,  S_MAX);
        queue_beat(swmm_pkg::MODE_ABS,  -32'sd3);
        queue_beat(swmm_pkg::MODE_ABS,  32'sd7);
        queue_beat(swmm_pkg::MODE_FILL, -32'sd5);
        // negative sum not divisible by the length: mean rounds toward zero
        queue_beat(swmm_pkg::MODE_ABS,  -32'sd2);
        queue_beat(swmm_pkg::MODE_FILL, 32'sd0);
        queue_beat(swmm_pkg::MODE_ABS,  32'sd1);
        queue_beat(swmm_pkg::MODE_ABS,  32'sh5555_5555);
        queue_beat(swmm_pkg::MODE_ABS,  32'shAAAA_AAAA);
        queue_beat(swmm_pkg::MODE_HOLD, S_MIN);

        phase_len = '{7'd1, 7'd2, 7'd0, 7'd127, 7'd5, 7'd100, 7'd1, 7'd1, 7'd17, 7'd33, 7'd64};
        phase_len[6] = len_cfg_t'($urandom_range(1, RING_DEPTH));
        phase_len[7] = len_cfg_t'($urandom_range(1, RING_DEPTH));

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            @(posedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= phase_len[p];
            @(posedge clk);
            cfg_wr_en   <= 1'b0;

            // length write restarts the ring and rebuilds sum and extremes
            win_len_cfg = phase_len[p];
            n = used_len();
            win_sum = 0;
            for (int i = 0; i < n; i++)
            begin
                win_sum += longint'(win_ring[i]);
            end
            wr_pos = 0;
            lo_pos = find_lowest(0, n);
            hi_pos = find_highest(0, n);

            if (p == PHASES - 1)
            begin
                allow_idle = 1'b0;
            end

            for (int k = 0; k < PHASE_BEATS; k++)
            begin
                r = $urandom_range(0, 99);
                v = pick_value();
                if (r < 50)
                begin
                    queue_beat(swmm_pkg::MODE_ABS, v);
                end
                else if (r < 85)
                begin
                    queue_beat(swmm_pkg::MODE_INC, v);
                end
                else if (r < 93)
                begin
                    queue_beat(swmm_pkg::MODE_FILL, v);
                end
                else
                begin
                    queue_beat(swmm_pkg::MODE_HOLD, v);
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
